### src/fwrv_pkg.sv
`timescale 1ns / 1ps
package fwrv_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic                     push_en;
		logic                     pop_en;
		logic                     remove_en;
		logic signed [WORD_W-1:0] value;
	} cell_ctl_t;

endpackage

### src/fifo_with_remove_by_value.sv
`timescale 1ns / 1ps
// Bounded queue of signed words with push, pop and remove-first-match. One transaction is
// taken every clock cycle (busy stays low); its result appears on the result ports with
// strobe high in the cycle after start, for exactly one cycle, and must be captured then
// since the receiver cannot stall. A row of DEPTH cells compares against the search word in
// parallel and shifts towards the head to close a gap.
module fifo_with_remove_by_value
	import fwrv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               operation,
	input  logic signed [WORD_W-1:0] item_value,
	output logic                     strobe,
	output logic signed [WORD_W-1:0] result_value,
	output logic [1:0]               status,
	output logic [CNT_W-1:0]         occupancy
);

	logic [CNT_W-1:0]         count_q;
	logic                     strobe_q;
	logic signed [WORD_W-1:0] result_q;
	status_t                  status_q;
	logic [CNT_W-1:0]         occ_q;

	logic signed [WORD_W-1:0] words [DEPTH];
	logic [DEPTH:0]           hit;
	logic                     accept;
	logic                     full;
	logic                     empty;
	op_t                      op;
	cell_ctl_t                ctl;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign op     = op_t'(operation);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign hit[0] = 1'b0;

	assign ctl.push_en   = accept && (op == OP_PUSH) && !full;
	assign ctl.pop_en    = accept && (op == OP_POP) && !empty;
	assign ctl.remove_en = accept && (op == OP_REMOVE);
	assign ctl.value     = item_value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = words[i];
		end else begin : g_mid
			assign nxt = words[i+1];
		end
		fwrv_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (CNT_W'(i) < count_q),
			.at_tail   (CNT_W'(i) == count_q),
			.hit_in    (hit[i]),
			.next_word (nxt),
			.word_q    (words[i]),
			.hit_out   (hit[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			strobe_q <= 1'b0;
			status_q <= ST_OK;
			occ_q    <= '0;
		end else begin
			strobe_q <= accept;
			if (accept) begin
				unique case (op)
					OP_PUSH: begin
						status_q <= full ? ST_FULL : ST_OK;
						if (!full) begin
							count_q <= count_q + 1'b1;
							occ_q   <= count_q + 1'b1;
						end else begin
							occ_q <= count_q;
						end
					end
					OP_POP: begin
						status_q <= empty ? ST_EMPTY : ST_OK;
						if (!empty) begin
							count_q <= count_q - 1'b1;
							occ_q   <= count_q - 1'b1;
						end else begin
							occ_q <= count_q;
						end
					end
					OP_REMOVE: begin
						status_q <= hit[DEPTH] ? ST_OK : ST_NOT_FOUND;
						if (hit[DEPTH]) begin
							count_q <= count_q - 1'b1;
							occ_q   <= count_q - 1'b1;
						end else begin
							occ_q <= count_q;
						end
					end
					default: begin
						status_q <= ST_OK;
						occ_q    <= count_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (op)
				OP_PUSH:   result_q <= item_value;
				OP_POP:    result_q <= empty ? -32'sd1 : words[0];
				OP_REMOVE: result_q <= hit[DEPTH] ? item_value : -32'sd1;
				default:   result_q <= '0;
			endcase
		end
	end

	assign strobe       = strobe_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (occupancy <= CNT_W'(DEPTH)))
		else $error("occupancy exceeds depth");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status == ST_FULL)) |-> (occupancy == CNT_W'(DEPTH)))
		else $error("full status with free space");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status == ST_EMPTY)) |-> (occupancy == '0))
		else $error("empty status with entries held");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy))
		else $error("result without transaction");

endmodule

### src/fwrv_cell.sv
`timescale 1ns / 1ps
module fwrv_cell
	import fwrv_pkg::*;
(
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic                     occupied,
	input  logic                     at_tail,
	input  logic                     hit_in,
	input  logic signed [WORD_W-1:0] next_word,
	output logic signed [WORD_W-1:0] word_q,
	output logic                     hit_out
);

	logic match;

	assign match   = occupied && (word_q == ctl.value);
	assign hit_out = hit_in || match;

	always_ff @(posedge clk) begin
		priority if (ctl.push_en && at_tail) begin
			word_q <= ctl.value;
		end else if (ctl.pop_en) begin
			word_q <= next_word;
		end else if (ctl.remove_en && hit_out) begin
			word_q <= next_word;
		end else begin
			word_q <= word_q;
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import fwrv_pkg::*;

	typedef struct {
		logic signed [WORD_W-1:0] value;
		status_t                  st;
		logic [CNT_W-1:0]         occ;
	} queue_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               operation;
	logic signed [WORD_W-1:0] item_value;
	logic                     strobe;
	logic signed [WORD_W-1:0] result_value;
	logic [1:0]               status;
	logic [CNT_W-1:0]         occupancy;

	logic signed [WORD_W-1:0] model_words[$];
	queue_result_t            pending_results[$];
	int                       mismatch_count = 0;

	fifo_with_remove_by_value uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.item_value   (item_value),
		.strobe       (strobe),
		.result_value (result_value),
		.status       (status),
		.occupancy    (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb_top: errors");
		$finish;
	end

	function automatic queue_result_t apply_command(op_t op, logic signed [WORD_W-1:0] word);
		queue_result_t r;
		int            idx;
		idx = -1;
		r.value = '0;
		r.st = ST_OK;
		case (op)
			OP_PUSH: begin
				r.value = word;
				if (model_words.size() >= DEPTH)
					r.st = ST_FULL;
				else
					model_words.push_back(word);
			end
			OP_POP: begin
				if (model_words.size() == 0) begin
					r.value = -1;
					r.st = ST_EMPTY;
				end else begin
					r.value = model_words.pop_front();
				end
			end
			OP_REMOVE: begin
				for (int k = 0; k < model_words.size(); k++) begin
					if (idx < 0 && model_words[k] == word)
						idx = k;
				end
				if (idx >= 0) begin
					r.value = model_words[idx];
					model_words.delete(idx);
				end else begin
					r.value = -1;
					r.st = ST_NOT_FOUND;
				end
			end
			default: begin
				r.value = '0;
			end
		endcase
		r.occ = CNT_W'(model_words.size());
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
	endtask

	task automatic send_command(op_t op, logic signed [WORD_W-1:0] word);
		@(negedge clk);
		start = 1'b1;
		operation = op;
		item_value = word;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(apply_command(op, word));
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	always @(posedge clk) begin : check_results
		queue_result_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", result_value, '0);
			end else begin
				want = pending_results.pop_front();
				if (result_value !== want.value)
					report_mismatch("result_value", result_value, want.value);
				if (status !== want.st)
					report_mismatch("status", 32'(status), 32'(want.st));
				if (occupancy !== want.occ)
					report_mismatch("occupancy", 32'(occupancy), 32'(want.occ));
			end
		end
	end

	task automatic test_empty_queue();
		send_command(OP_POP, 32'sh0000_0000);
		send_command(OP_REMOVE, 32'sh0000_0000);
		send_command(OP_REMOVE, -32'sd1);
		send_command(OP_NONE, 32'sh5A5A_A5A5);
		idle_cycles(2);
	endtask

	task automatic test_fill_and_overflow();
		send_command(OP_PUSH, 32'sh8000_0000);
		send_command(OP_PUSH, 32'sh7FFF_FFFF);
		send_command(OP_PUSH, -32'sd1);
		send_command(OP_PUSH, 32'sd0);
		send_command(OP_PUSH, 32'sd5);
		send_command(OP_PUSH, 32'sd1);
		send_command(OP_PUSH, 32'sd5);
		for (int i = 1; i <= 9; i++)
			send_command(OP_PUSH, i * 32'sh0101_0101);
		send_command(OP_PUSH, 32'sh1234_5678);
		idle_cycles(1);
	endtask

	task automatic test_remove_by_value();
		send_command(OP_REMOVE, 32'sd5);
		send_command(OP_REMOVE, -32'sd1);
		send_command(OP_REMOVE, 32'sh8000_0000);
		send_command(OP_REMOVE, 32'sh0909_0909);
		send_command(OP_REMOVE, 32'sd99);
		idle_cycles(3);
	endtask

	task automatic test_random_traffic(int n_items);
		int                       sent;
		int                       burst;
		int                       bias;
		int                       r;
		int                       push_lim;
		int                       pop_lim;
		op_t                      op;
		logic signed [WORD_W-1:0] word;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(1, 24);
			bias = $urandom_range(0, 2);
			push_lim = (bias == 0) ? 70 : (bias == 1) ? 40 : 20;
			pop_lim = (bias == 0) ? 80 : (bias == 1) ? 65 : 60;
			for (int b = 0; b < burst && sent < n_items; b++) begin
				r = $urandom_range(0, 99);
				if (r < push_lim)
					op = OP_PUSH;
				else if (r < pop_lim)
					op = OP_POP;
				else if (r < 97)
					op = OP_REMOVE;
				else
					op = OP_NONE;
				r = $urandom_range(0, 9);
				if (op == OP_REMOVE && r < 6 && model_words.size() > 0)
					word = model_words[$urandom_range(0, model_words.size() - 1)];
				else if (op != OP_POP && r < 8)
					word = $signed($urandom_range(0, 7)) - 32'sd4;
				else
					word = $urandom;
				send_command(op, word);
				if (op != OP_NONE)
					sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 6));
		end
		idle_cycles(1);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_PUSH;
		item_value = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		idle_cycles(2);

		test_empty_queue();
		test_fill_and_overflow();
		test_remove_by_value();
		test_random_traffic(850);

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

### fifo_with_remove_by_value.f
src/fwrv_pkg.sv
src/fwrv_cell.sv
src/fifo_with_remove_by_value.sv
sim/tb_top.sv
